FILE: hdl/ehp_pkg.sv
// Shared constants and types for the Ethernet/IP/L4 header parser.
package ehp_pkg;

  // Frame geometry
  localparam int DEFAULT_MAX_FRAME_BYTES = 16384;
  localparam int ETYPE_HI_POS            = 12;
  localparam int TAG_CHECK_POS           = 13;
  localparam int ETH_HDR_BYTES           = 14;
  localparam int IPV4_MIN_HDR_BYTES      = 20;
  localparam int IPV6_HDR_BYTES          = 40;
  localparam int PORT_BYTES              = 4;

  // IPv4 header offsets
  localparam int V4_PROTO_OFS   = 9;
  localparam int V4_SRC_OFS     = 12;
  localparam int V4_DST_OFS     = 16;
  localparam int V4_ADDR_BYTES  = 4;

  // IPv6 header offsets
  localparam int V6_PROTO_OFS   = 6;
  localparam int V6_ADDR_OFS    = 8;

  // Tag sizes and field codes
  localparam logic [3:0]  SINGLE_TAG_BYTES = 4'd4;
  localparam logic [3:0]  DOUBLE_TAG_BYTES = 4'd8;
  localparam logic [7:0]  IHL_MASK         = 8'h0F;
  localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6       = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  // Configuration register reset values
  localparam logic [15:0] SINGLE_TAG_RESET = 16'h8100;
  localparam logic [15:0] DOUBLE_TAG_RESET = 16'h88A8;

  typedef enum logic [0:0] {
    CFG_SINGLE_TAG = 1'b0,
    CFG_DOUBLE_TAG = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_PORTS    = 3'd0,
    ST_NO_PORTS = 3'd1,
    ST_NOT_IP   = 3'd2,
    ST_SHORT    = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

endpackage

FILE: hdl/ehp_if.sv
// Byte input and summary output channel interfaces of the header parser.
interface ehp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, frame_byte, end_of_frame, input ready);
  modport sink   (input valid, frame_byte, end_of_frame, output ready);
endinterface

interface ehp_sum_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] ether_type_out;
  logic        is_ipv6;
  logic [7:0]  l4_protocol;
  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;
  logic [63:0] dst_addr_high;
  logic [63:0] dst_addr_low;
  logic [15:0] src_port_out;
  logic [15:0] dst_port_out;

  modport source (output valid, status, ether_type_out, is_ipv6, l4_protocol,
                  src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
                  src_port_out, dst_port_out, input ready);
  modport sink   (input valid, status, ether_type_out, is_ipv6, l4_protocol,
                  src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
                  src_port_out, dst_port_out, output ready);
endinterface

FILE: hdl/ethernet_ip_l4_header_parser.sv
// Top level of the Ethernet/VLAN/IPv4/IPv6/TCP/UDP header parser.
//
// Usage:
//   byte_in  - one frame byte per transaction, in wire order; end_of_frame
//              marks the final byte. Frames follow each other with no gap.
//   res_out  - one summary transaction per frame: status, EtherType after any
//              VLAN tags, IP version, layer-4 protocol, addresses and ports.
//   cfg_*    - write port for the single and double VLAN tag EtherTypes;
//              write only while no frame is in progress.
// Throughput: one byte per cycle. Each byte passes an input register, then
// one pass of position compares and field captures into the frame state.
// The summary is registered as the final byte leaves the input register.
// A stalled summary holds in the output register; bytes that do not end a
// frame keep flowing meanwhile, and only a final byte waits in the input
// register until the summary ahead of it is taken.
// Reset: clears the frame state and the output valid flag and restores the
// tag registers to 0x8100 and 0x88A8. Bytes beyond MAX_FRAME_BYTES are
// dropped and the length saturates there.
module ethernet_ip_l4_header_parser
  import ehp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  ehp_byte_if.sink    byte_in,
  ehp_sum_if.source   res_out
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  // Configuration registers
  logic [15:0] single_tag_q, double_tag_q;

  // Input register
  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       s0_last_q;
  logic       s0_fire, in_ready;

  // Frame state
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [3:0]           tag_q, tag_d;
  logic [15:0]          et_q, et_d;
  logic [5:0]           ihb_q, ihb_d;
  logic [7:0]           proto_q, proto_d;
  logic [3:0][63:0]     addr_q, addr_d;   // src high, src low, dst high, dst low
  logic [3:0][7:0]      port_q, port_d;   // src port hi/lo, dst port hi/lo
  logic [2:0]           seen_q, seen_d;

  // Output register
  logic        out_valid_q;
  status_e     res_status_q, status_c;
  logic [15:0] res_et_q;
  logic        res_v6_q;
  logic [7:0]  res_proto_q;
  logic [3:0][63:0] res_addr_q;
  logic [15:0] res_sport_q, res_dport_q;
  logic        out_load;

  // Per-byte decode
  logic [CW-1:0] pos, type_pos, l3, rel, prel4;
  logic          take;
  logic [3:0]    addr_we;
  logic [2:0]    addr_lane;
  logic          port_we;
  logic [1:0]    port_idx;

  // Summary decode
  logic [CW-1:0] l3f;
  logic          v4, v6, ip_valid;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_tag_q <= SINGLE_TAG_RESET;
      double_tag_q <= DOUBLE_TAG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SINGLE_TAG: single_tag_q <= cfg_wdata_i;
        CFG_DOUBLE_TAG: double_tag_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold a final byte only while the previous summary is still stalled
  assign s0_fire  = s0_valid_q && (!s0_last_q || !out_valid_q || res_out.ready);
  assign in_ready = !s0_valid_q || s0_fire;
  assign byte_in.ready = in_ready;
  assign out_load = s0_fire && s0_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready) begin
      s0_valid_q <= byte_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && byte_in.valid) begin
      s0_byte_q <= byte_in.frame_byte;
      s0_last_q <= byte_in.end_of_frame;
    end
  end

  // Position compares for the current byte
  assign pos      = cnt_q;
  assign take     = s0_fire && (cnt_q < CW'(MAX_FRAME_BYTES));
  assign type_pos = CW'(ETYPE_HI_POS) + CW'(tag_q);
  assign l3       = CW'(ETH_HDR_BYTES) + CW'(tag_q);
  assign rel      = pos - l3;
  assign prel4    = rel - CW'(ihb_q);

  // Capture fields at their byte positions
  always_comb begin
    cnt_d     = cnt_q;
    tag_d     = tag_q;
    et_d      = et_q;
    ihb_d     = ihb_q;
    proto_d   = proto_q;
    seen_d    = seen_q;
    addr_we   = '0;
    addr_lane = '0;
    port_we   = 1'b0;
    port_idx  = '0;
    if (take) begin
      cnt_d = cnt_q + CW'(1);
      if (pos == type_pos) begin
        et_d[15:8] = s0_byte_q;
      end else if (pos == type_pos + CW'(1)) begin
        et_d[7:0] = s0_byte_q;
      end
      if (pos == CW'(TAG_CHECK_POS)) begin
        if (et_d == single_tag_q) begin
          tag_d = SINGLE_TAG_BYTES;
        end else if (et_d == double_tag_q) begin
          tag_d = DOUBLE_TAG_BYTES;
        end
      end else if (pos >= l3) begin
        if (et_q == ETYPE_IPV4) begin
          if (rel == '0) begin
            ihb_d = {4'((s0_byte_q & IHL_MASK)), 2'b00};
          end else if (rel == CW'(V4_PROTO_OFS)) begin
            proto_d = s0_byte_q;
          end else if (rel >= CW'(V4_SRC_OFS) && rel < CW'(V4_SRC_OFS + V4_ADDR_BYTES)) begin
            addr_we[1] = 1'b1;
            addr_lane  = {1'b1, rel[1:0]};
          end else if (rel >= CW'(V4_DST_OFS) && rel < CW'(V4_DST_OFS + V4_ADDR_BYTES)) begin
            addr_we[3] = 1'b1;
            addr_lane  = {1'b1, rel[1:0]};
          end
          if (rel != '0 && ihb_q >= 6'(IPV4_MIN_HDR_BYTES) && rel >= CW'(ihb_q) &&
              prel4 < CW'(PORT_BYTES)) begin
            port_we  = 1'b1;
            port_idx = prel4[1:0];
          end
        end else if (et_q == ETYPE_IPV6) begin
          if (rel == CW'(V6_PROTO_OFS)) begin
            proto_d = s0_byte_q;
          end else if (rel >= CW'(V6_ADDR_OFS) && rel < CW'(IPV6_HDR_BYTES)) begin
            addr_we[2'(rel[5:3] - 3'd1)] = 1'b1;
            addr_lane = rel[2:0];
          end else if (rel >= CW'(IPV6_HDR_BYTES) &&
                       rel < CW'(IPV6_HDR_BYTES + PORT_BYTES)) begin
            port_we  = 1'b1;
            port_idx = rel[1:0];
          end
        end
      end
      if (port_we && seen_q < 3'(PORT_BYTES)) begin
        seen_d = seen_q + 3'd1;
      end
    end
  end

  // Merge address and port bytes
  always_comb begin
    addr_d = addr_q;
    port_d = port_q;
    for (int w = 0; w < 4; w++) begin
      for (int l = 0; l < 8; l++) begin
        if (addr_we[w] && addr_lane == 3'(l)) begin
          addr_d[w][63-8*l -: 8] = s0_byte_q;
        end
      end
    end
    if (port_we) begin
      port_d[port_idx] = s0_byte_q;
    end
  end

  // Advance frame state; drop it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      tag_q   <= '0;
      et_q    <= '0;
      ihb_q   <= '0;
      proto_q <= '0;
      addr_q  <= '0;
      port_q  <= '0;
      seen_q  <= '0;
    end else if (s0_fire) begin
      cnt_q   <= s0_last_q ? '0 : cnt_d;
      tag_q   <= s0_last_q ? '0 : tag_d;
      et_q    <= s0_last_q ? '0 : et_d;
      ihb_q   <= s0_last_q ? '0 : ihb_d;
      proto_q <= s0_last_q ? '0 : proto_d;
      addr_q  <= s0_last_q ? '0 : addr_d;
      port_q  <= s0_last_q ? '0 : port_d;
      seen_q  <= s0_last_q ? '0 : seen_d;
    end
  end

  // Classify the frame from its state after the final byte
  assign l3f = CW'(ETH_HDR_BYTES) + CW'(tag_d);
  assign v4  = (et_d == ETYPE_IPV4);
  assign v6  = (et_d == ETYPE_IPV6);

  always_comb begin
    if (cnt_d < l3f) begin
      status_c = ST_SHORT;
    end else if (!v4 && !v6) begin
      status_c = ST_NOT_IP;
    end else if (v4 && (cnt_d < l3f + CW'(IPV4_MIN_HDR_BYTES) ||
                        ihb_d < 6'(IPV4_MIN_HDR_BYTES) || cnt_d < l3f + CW'(ihb_d))) begin
      status_c = ST_TRUNC;
    end else if (v6 && cnt_d < l3f + CW'(IPV6_HDR_BYTES)) begin
      status_c = ST_TRUNC;
    end else if (proto_d inside {PROTO_TCP, PROTO_UDP}) begin
      status_c = (seen_d == 3'(PORT_BYTES)) ? ST_PORTS : ST_TRUNC;
    end else begin
      status_c = ST_NO_PORTS;
    end
  end

  assign ip_valid = status_c inside {ST_PORTS, ST_NO_PORTS, ST_TRUNC};

  // Output register: load a summary, hold it until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_status_q <= status_c;
      res_et_q     <= (status_c == ST_SHORT) ? '0 : et_d;
      res_v6_q     <= ip_valid && v6;
      res_proto_q  <= ip_valid ? proto_d : '0;
      res_addr_q   <= ip_valid ? addr_d : '0;
      res_sport_q  <= (status_c == ST_PORTS) ? {port_d[0], port_d[1]} : '0;
      res_dport_q  <= (status_c == ST_PORTS) ? {port_d[2], port_d[3]} : '0;
    end
  end

  assign res_out.valid          = out_valid_q;
  assign res_out.status         = res_status_q;
  assign res_out.ether_type_out = res_et_q;
  assign res_out.is_ipv6        = res_v6_q;
  assign res_out.l4_protocol    = res_proto_q;
  assign res_out.src_addr_high  = res_addr_q[0];
  assign res_out.src_addr_low   = res_addr_q[1];
  assign res_out.dst_addr_high  = res_addr_q[2];
  assign res_out.dst_addr_low   = res_addr_q[3];
  assign res_out.src_port_out   = res_sport_q;
  assign res_out.dst_port_out   = res_dport_q;

  // Frame state starts over after each final byte
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_fire && s0_last_q) |=> (cnt_q == '0 && seen_q == '0 && tag_q == '0))
    else $error("frame state not cleared after final byte");

  // A summary appears only after a final byte was processed
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s0_fire && s0_last_q))
    else $error("summary raised without a final byte");

  // Ports are reported only with the ports-found status
  a_ports_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_status_q != ST_PORTS) |-> (res_sport_q == '0 && res_dport_q == '0))
    else $error("ports reported without ports-found status");

  // Port byte count saturates at four
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= 3'(PORT_BYTES))
    else $error("port byte count out of range");

endmodule
